[sv/pbp_pkg.sv]
package pbp_pkg;

  localparam int unsigned TableEntries = 65536;
  localparam int unsigned AddrW        = 16;
  localparam int unsigned WordBits     = 64;
  localparam int unsigned CodeW        = 32;   // entry_code port width
  localparam int unsigned LenW         = 6;    // entry_length port width
  localparam int unsigned WordsW       = 10;   // full-word counter per key
  localparam int unsigned FillW        = 6;    // pending bits, 0..63
  localparam int unsigned TotalW       = 16;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueueCntW    = 3;
  localparam int unsigned QueuePtrW    = 2;
  localparam int unsigned InDataW      = 72;
  localparam int unsigned InUserW      = 2;
  localparam int unsigned OutDataW     = 80;   // packed word plus total count

  // tuser[0] selector values
  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeEncode = 1'b1;

  localparam logic [WordsW-1:0] WordsMax = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;

  // one looked-up code waiting for the packer
  typedef struct packed {
    logic             eok;
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } entry_t;

endpackage

[sv/pbp_ram.sv]
module pbp_ram import pbp_pkg::*; #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pbp_front.sv]
module pbp_front import pbp_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [AddrW-1:0]     entry_index_i,
  input  logic [CodeW-1:0]     entry_code_i,
  input  logic [LenW-1:0]      entry_length_i,
  input  logic [7:0]           first_byte_i,
  input  logic [7:0]           second_byte_i,
  input  logic                 second_present_i,
  input  logic                 end_of_key_i,
  input  logic [QueueCntW-1:0] queue_count_i,
  output logic                 push_o,
  output entry_t               push_entry_o
);

  localparam int unsigned StoreLenW = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned StoreW    = StoreLenW + MAX_CODE_BITS;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_CODE_BITS);

  logic                  accept;
  logic                  do_load;
  logic                  do_read;
  logic [LenW-1:0]       len_clip;
  logic [CodeW:0]        len_mask;
  logic [CodeW-1:0]      code_clip;
  logic [StoreW-1:0]     wdata;
  logic [StoreW-1:0]     rdata;
  logic [AddrW-1:0]      sym;
  logic                  rd_valid_d, rd_valid_q;
  logic                  rd_eok_d, rd_eok_q;
  logic [QueueCntW:0]    used;

  // reserve a queue slot for the read still in flight
  assign used       = {1'b0, queue_count_i} + {{QueueCntW{1'b0}}, rd_valid_q};
  assign in_ready_o = (used < (QueueCntW + 1)'(QueueDepth));
  assign accept     = in_valid_i && in_ready_o;
  assign do_load    = accept && (mode_i == ModeLoad);
  assign do_read    = accept && (mode_i == ModeEncode);

  // clip the length and drop stray code bits above it
  assign len_clip  = (entry_length_i > MaxLen) ? MaxLen : entry_length_i;
  assign len_mask  = ((CodeW + 1)'(1) << len_clip) - (CodeW + 1)'(1);
  assign code_clip = entry_code_i & len_mask[CodeW-1:0];
  assign wdata     = {len_clip[StoreLenW-1:0], code_clip[MAX_CODE_BITS-1:0]};

  assign sym = {first_byte_i, (second_present_i ? second_byte_i : 8'h00)};

  pbp_ram #(
    .WIDTH (StoreW),
    .DEPTH (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (entry_index_i),
    .wdata_i (wdata),
    .re_i    (do_read),
    .raddr_i (sym),
    .rdata_o (rdata)
  );

  assign rd_valid_d = do_read;
  assign rd_eok_d   = do_read ? end_of_key_i : rd_eok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_eok_q <= rd_eok_d;
  end

  assign push_o            = rd_valid_q;
  assign push_entry_o.eok  = rd_eok_q;
  assign push_entry_o.len  = LenW'(rdata[StoreW-1:MAX_CODE_BITS]);
  assign push_entry_o.code = CodeW'(rdata[MAX_CODE_BITS-1:0]);

endmodule

[sv/pbp_queue.sv]
module pbp_queue import pbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  entry_t               push_entry_i,
  input  logic                 pop_i,
  output logic                 nonempty_o,
  output entry_t               head_o,
  output logic [QueueCntW-1:0] count_o
);

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_d, wptr_q;
  logic [QueuePtrW-1:0] rptr_d, rptr_q;
  logic [QueueCntW-1:0] count_d, count_q;
  logic                 do_pop;

  assign do_pop     = pop_i && (count_q != '0);
  assign wptr_d     = push_i ? wptr_q + QueuePtrW'(1) : wptr_q;
  assign rptr_d     = do_pop ? rptr_q + QueuePtrW'(1) : rptr_q;
  assign count_d    = count_q + QueueCntW'(push_i) - QueueCntW'(do_pop);
  assign nonempty_o = (count_q != '0);
  assign head_o     = mem_q[rptr_q];
  assign count_o    = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

[sv/pbp_back.sv]
module pbp_back import pbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                nonempty_i,
  input  entry_t              head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WordBits-1:0] out_word_o,
  output logic                out_last_o,
  output logic [TotalW-1:0]   out_total_o
);

  // accumulator is kept left-justified: pending bits sit at the top
  logic [WordBits-1:0] acc_d, acc_q;
  logic [FillW-1:0]    fill_d, fill_q;
  logic [WordsW-1:0]   words_d, words_q;
  logic                over_d, over_q;
  logic                pend_d, pend_q;
  logic [WordBits-1:0] pend_word_d, pend_word_q;
  logic [TotalW-1:0]   pend_total_d, pend_total_q;
  logic                oval_d, oval_q;
  logic [WordBits-1:0] oword_d, oword_q;
  logic                olast_d, olast_q;
  logic [TotalW-1:0]   ototal_d, ototal_q;

  logic                out_free;
  logic [FillW:0]      sum;
  logic                ovf;
  logic [FillW-1:0]    rest;
  logic [WordBits-1:0] code64;
  logic [WordBits-1:0] full_word;
  logic [WordBits-1:0] acc_new;
  logic [FillW-1:0]    fill_new;
  logic [WordsW-1:0]   words_new;
  logic                over_new;
  logic [TotalW-1:0]   total_new;
  logic                gives;

  assign out_free  = !oval_q || out_ready_i;
  assign sum       = {1'b0, fill_q} + (FillW + 1)'(head_i.len);
  assign ovf       = sum[FillW];
  assign rest      = sum[FillW-1:0];
  assign code64    = WordBits'(head_i.code);
  assign full_word = acc_q | (code64 >> rest);
  assign acc_new   = ovf ? (code64 << (7'd64 - {1'b0, rest}))
                         : (acc_q | (code64 << (7'd64 - sum)));
  assign fill_new  = rest;
  assign words_new = (ovf && (words_q != WordsMax)) ? words_q + WordsW'(1) : words_q;
  assign over_new  = over_q || (ovf && (words_q == WordsMax));
  assign total_new = over_new ? TotalMax : {words_new, fill_new};
  assign gives     = ovf || head_i.eok;

  // a pending final word blocks the queue until it moves out
  assign pop_o = nonempty_i && !pend_q && (out_free || !gives);

  always_comb begin
    acc_d        = acc_q;
    fill_d       = fill_q;
    words_d      = words_q;
    over_d       = over_q;
    pend_d       = pend_q;
    pend_word_d  = pend_word_q;
    pend_total_d = pend_total_q;
    oval_d       = oval_q && !out_ready_i;
    oword_d      = oword_q;
    olast_d      = olast_q;
    ototal_d     = ototal_q;

    if (pend_q && out_free) begin
      pend_d   = 1'b0;
      oval_d   = 1'b1;
      oword_d  = pend_word_q;
      olast_d  = 1'b1;
      ototal_d = pend_total_q;
    end

    if (pop_o) begin
      if (head_i.eok) begin
        acc_d   = '0;
        fill_d  = '0;
        words_d = '0;
        over_d  = 1'b0;
      end else begin
        acc_d   = acc_new;
        fill_d  = fill_new;
        words_d = words_new;
        over_d  = over_new;
      end
      if (ovf) begin
        oval_d   = 1'b1;
        oword_d  = full_word;
        olast_d  = 1'b0;
        ototal_d = '0;
        if (head_i.eok) begin
          // hold the final word back until the full word ahead of it moves out
          pend_d       = 1'b1;
          pend_word_d  = acc_new;
          pend_total_d = total_new;
        end
      end else if (head_i.eok) begin
        oval_d   = 1'b1;
        oword_d  = acc_new;
        olast_d  = 1'b1;
        ototal_d = total_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      fill_q  <= '0;
      words_q <= '0;
      over_q  <= 1'b0;
      pend_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      fill_q  <= fill_d;
      words_q <= words_d;
      over_q  <= over_d;
      pend_q  <= pend_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_word_q  <= pend_word_d;
    pend_total_q <= pend_total_d;
    oword_q      <= oword_d;
    olast_q      <= olast_d;
    ototal_q     <= ototal_d;
  end

  assign out_valid_o = oval_q;
  assign out_word_o  = oword_q;
  assign out_last_o  = olast_q;
  assign out_total_o = ototal_q;

endmodule

[sv/pair_code_bit_packer_core.sv]
// Channel   Dir  Signals                      Carries
// s_axis    in   tvalid/tready/tdata/tuser/   load: slot, code, length;
//                tlast                        encode: byte pair, end of key
// m_axis    out  tvalid/tready/tdata/tlast    64-bit packed word, total bit
//                                             count, final-word mark
//
// One input transfer per cycle while the queue has room. An encode item that
// yields both a full word and the final word sends them as two output words.
// Input reaches the output through the dictionary read (registered RAM port),
// the queue and the output register. Reset clears packing state and the
// queue; the dictionary is not cleared and must be loaded before use. Either
// side can stall alone: the queue absorbs output back-pressure until it fills.
module pair_code_bit_packer_core import pbp_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // entry_index[15:0], entry_code[47:16], entry_length[53:48],
  // first_byte[61:54], second_byte[69:62], zero pad[71:70]
  input  logic [InDataW-1:0] s_axis_tdata_i,
  // mode[0], second_present[1]
  input  logic [InUserW-1:0] s_axis_tuser_i,
  input  logic               s_axis_tlast_i,   // end_of_key
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // packed_word[63:0], total_bits[79:64]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic               m_axis_tlast_o    // is_last
);

  logic                 push;
  entry_t               push_entry;
  logic                 pop;
  logic                 nonempty;
  entry_t               head;
  logic [QueueCntW-1:0] queue_count;
  logic [WordBits-1:0]  out_word;
  logic [TotalW-1:0]    out_total;

  // front: classify transfers, write or read the dictionary
  pbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .mode_i           (s_axis_tuser_i[0]),
    .entry_index_i    (s_axis_tdata_i[15:0]),
    .entry_code_i     (s_axis_tdata_i[47:16]),
    .entry_length_i   (s_axis_tdata_i[53:48]),
    .first_byte_i     (s_axis_tdata_i[61:54]),
    .second_byte_i    (s_axis_tdata_i[69:62]),
    .second_present_i (s_axis_tuser_i[1]),
    .end_of_key_i     (s_axis_tlast_i),
    .queue_count_i    (queue_count),
    .push_o           (push),
    .push_entry_o     (push_entry)
  );

  // looked-up codes waiting for the packer
  pbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .nonempty_o   (nonempty),
    .head_o       (head),
    .count_o      (queue_count)
  );

  // back: pack codes MSB-first and emit words
  pbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (out_word),
    .out_last_o  (m_axis_tlast_o),
    .out_total_o (out_total)
  );

  assign m_axis_tdata_o = {out_total, out_word};

endmodule
